[sv/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: command and
// status codes, the per-cell operation code and the stream word layout.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Field widths of one input and one result word
    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int FPOS_W  = 5;
    localparam int ECNT_W  = 5;
    localparam int STAT_W  = 2;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SEARCH = 2'd3
    } ple_cmd_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_PAST  = 2'd3
    } ple_status_t;

    // Operation broadcast along the row of cells
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_READ,
        OP_SEARCH
    } ple_op_t;

endpackage

[sv/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// One list slot. Holds one entry and, per broadcast operation, loads the new
// value, takes its left or right neighbour's entry, or holds. Also reports
// its entry for a read and an equality hit for a search.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                         aclk,
    input  ple_pkg::ple_op_t             op,
    input  logic [CW-1:0]                slot,
    input  logic [CW-1:0]                cnt,
    input  logic [ple_pkg::VAL_W-1:0]    item_value,
    input  logic [ple_pkg::VAL_W-1:0]    left_value,
    input  logic [ple_pkg::VAL_W-1:0]    right_value,
    output logic [ple_pkg::VAL_W-1:0]    value,
    output logic [ple_pkg::VAL_W-1:0]    rd_part,
    output logic                         hit
);
    import ple_pkg::*;

    localparam logic [CW:0] IDX_W = (CW+1)'(IDX);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic [CW:0]      slot_w;
    logic [CW:0]      cnt_w;

    assign slot_w = {1'b0, slot};
    assign cnt_w  = {1'b0, cnt};

    // Per-cell move decision
    always_comb begin
        value_next = value_reg;
        case (op)
            OP_INSERT: begin
                if (IDX_W == slot_w) begin
                    value_next = item_value;
                end else if (IDX_W > slot_w && IDX_W <= cnt_w) begin
                    value_next = left_value;
                end
            end
            OP_REMOVE: begin
                if (IDX_W >= slot_w && IDX_W + 1'b1 < cnt_w) begin
                    value_next = right_value;
                end
            end
            default: value_next = value_reg;
        endcase
    end

    // Entry storage, undefined until written
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign rd_part = (op == OP_READ && slot_w == IDX_W) ? value_reg : '0;
    assign hit     = (op == OP_SEARCH) && (IDX_W < cnt_w) && (value_reg == item_value);

endmodule

[sv/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells,
// with insert, remove, read and search at a 1-based position.
// ----------------------------------------------------------------------------
// Pipeline: the cell stage loads the stage-one register, then the first-match
// encode loads the output register; every cell shifts or compares in parallel.
// Throughput: one word per cycle unless m_axis_tready stalls the output.
// Reset: aresetn (synchronous) clears the count and both valid flags; the
// entry cells are not cleared and are only read below the count.
module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] command, [6:2] position, [38:7] item_value, [39] zero
    input  logic [ple_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_value, [36:32] found_position, [41:37] entry_count,
    // [43:42] status, [47:44] zero
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Input word fields
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] item_value;

    assign cmd        = s_axis_tdata[1:0];
    assign pos        = s_axis_tdata[6:2];
    assign item_value = s_axis_tdata[38:7];

    logic s_fire;
    logic out_adv;

    // Control registers
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          m_valid_reg, m_valid_next;

    // Stage-one payload
    logic [DEPTH-1:0]  s1_hit_reg;
    logic [VAL_W-1:0]  s1_rd_reg;
    logic [ECNT_W-1:0] s1_cnt_reg;
    ple_status_t       s1_status_reg;
    logic              s1_search_reg;

    // Output payload
    logic [VAL_W-1:0]  m_rd_reg;
    logic [FPOS_W-1:0] m_found_reg;
    logic [ECNT_W-1:0] m_cnt_reg;
    ple_status_t       m_status_reg;

    // Command decode
    ple_op_t       op;
    logic [CW-1:0] slot;
    ple_status_t   status;
    logic [XW-1:0] pos_x, cnt_x, base_x;

    assign out_adv = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_adv;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    assign pos_x  = XW'(pos);
    assign cnt_x  = XW'(cnt_reg);
    assign base_x = (pos_x <= XW'(1)) ? '0 : pos_x - XW'(1);

    always_comb begin
        op       = OP_HOLD;
        slot     = '0;
        status   = ST_OK;
        cnt_next = cnt_reg;
        case (cmd)
            CMD_INSERT: begin
                if (cnt_reg == DEPTH_C) begin
                    status = ST_FULL;
                end else begin
                    op       = s_fire ? OP_INSERT : OP_HOLD;
                    slot     = (base_x > cnt_x) ? cnt_reg : CW'(base_x);
                    cnt_next = s_fire ? cnt_reg + 1'b1 : cnt_reg;
                end
            end
            CMD_REMOVE: begin
                if (cnt_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    op       = s_fire ? OP_REMOVE : OP_HOLD;
                    slot     = (base_x > cnt_x - XW'(1)) ? cnt_reg - 1'b1 : CW'(base_x);
                    cnt_next = s_fire ? cnt_reg - 1'b1 : cnt_reg;
                end
            end
            CMD_READ: begin
                if (cnt_reg == '0) begin
                    status = ST_EMPTY;
                end else if (pos_x > cnt_x) begin
                    status = ST_PAST;
                end else begin
                    op   = s_fire ? OP_READ : OP_HOLD;
                    slot = CW'(base_x);
                end
            end
            CMD_SEARCH: begin
                op = s_fire ? OP_SEARCH : OP_HOLD;
            end
            default: op = OP_HOLD;
        endcase
    end

    // Row of cells
    logic [VAL_W-1:0] cell_val [DEPTH];
    logic [VAL_W-1:0] cell_rd  [DEPTH];
    logic [DEPTH-1:0] cell_hit;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;
        if (i == 0) begin : g_head
            assign left_v = '0;
        end else begin : g_body_l
            assign left_v = cell_val[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_v = '0;
        end else begin : g_body_r
            assign right_v = cell_val[i+1];
        end
        ple_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk        (aclk),
            .op          (op),
            .slot        (slot),
            .cnt         (cnt_reg),
            .item_value  (item_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_val[i]),
            .rd_part     (cell_rd[i]),
            .hit         (cell_hit[i])
        );
    end

    // Read data: at most one cell drives a non-zero part
    logic [VAL_W-1:0] rd_or;
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // First match: isolate the lowest hit, then encode it
    logic [DEPTH-1:0]  first_hit;
    logic [FPOS_W-1:0] found;
    assign first_hit = s1_hit_reg & (~s1_hit_reg + DEPTH'(1));

    always_comb begin
        found = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_hit[i]) begin
                found = found | FPOS_W'(i + 1);
            end
        end
    end

    // Valid flags
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (out_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Stage-one payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_hit_reg    <= cell_hit;
            s1_rd_reg     <= rd_or;
            s1_cnt_reg    <= ECNT_W'(cnt_next);
            s1_status_reg <= status;
            s1_search_reg <= (cmd == CMD_SEARCH);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_rd_reg     <= s1_rd_reg;
            m_found_reg  <= s1_search_reg ? found : '0;
            m_cnt_reg    <= s1_cnt_reg;
            m_status_reg <= s1_status_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_status_reg, m_cnt_reg, m_found_reg, m_rd_reg};

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $onehot0(first_hit))
        else $error("more than one first match");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && cmd == CMD_INSERT && cnt_reg != DEPTH_C
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not grow the list");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_rd_reg == '0 && m_found_reg == '0)
        else $error("error word carries data");

endmodule
